FILE: rtl/core/fdcu_pkg.sv
// shared types and constants of the frame decoder
package fdcu_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7e;
    localparam logic [7:0] ESC_BYTE  = 8'h7d;
    localparam logic [7:0] ESC_XOR   = 8'h20;
    localparam logic [7:0] HDR0_BYTE = 8'h01;
    localparam logic [7:0] HDR1_BYTE = 8'h90;
    localparam logic [7:0] GOOD_SUM  = 8'hff;
    localparam logic [7:0] CHAR_CR   = 8'h0d;
    localparam logic [7:0] CHAR_LF   = 8'h0a;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        KIND_CODE    = 3'd0,
        KIND_TOKEN   = 3'd1,
        KIND_PAYLOAD = 3'd2,
        KIND_FEND    = 3'd3,
        KIND_TEXT    = 3'd4,
        KIND_TEND    = 3'd5,
        KIND_DISCARD = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_SHORT  = 2'd1,
        ERR_ESCAPE = 2'd2,
        ERR_HEADER = 2'd3
    } t_err;

    typedef enum logic [9:0] {
        PH_IDLE   = 10'b00_0000_0001,
        PH_TEXT   = 10'b00_0000_0010,
        PH_FRAME  = 10'b00_0000_0100,
        PH_GOT01  = 10'b00_0000_1000,
        PH_GOT90  = 10'b00_0001_0000,
        PH_GOTLEN = 10'b00_0010_0000,
        PH_SELECT = 10'b00_0100_0000,
        PH_HFRAME = 10'b00_1000_0000,
        PH_HTEXT  = 10'b01_0000_0000,
        PH_OWED   = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic        esc;
        logic [1:0]  cnt;
        logic [7:0]  held;
        logic [7:0]  sum;
        logic        cr;
        logic [15:0] left;
        logic [7:0]  lenh;
    } t_st;

    localparam t_st ST_RESET = '{PH_IDLE, 1'b0, 2'd0, 8'd0, 8'd0, 1'b0, 16'd0, 8'd0};

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        logic       checksum_ok;
        t_err       error_code;
        logic       last;
    } t_res;

    // up to two results of one byte, n says how many
    typedef struct packed {
        t_res       r0;
        t_res       r1;
        logic [1:0] n;
    } t_rbuf;

endpackage

FILE: rtl/core/fdcu_chan_if.sv
// handshake channels of the frame decoder: received bytes, results, mode register
interface fdcu_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface fdcu_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       checksum_ok;
    logic [1:0] error_code;
    logic       last;

    modport source (output valid, output out_byte, output kind, output checksum_ok,
                    output error_code, output last, input ready);
    modport sink (input valid, input out_byte, input kind, input checksum_ok,
                  input error_code, input last, output ready);
endinterface

interface fdcu_cfg_if;
    logic valid;
    logic ready;
    logic serial_mode;

    modport source (output valid, output serial_mode, input ready);
    modport sink (input valid, input serial_mode, output ready);
endinterface

FILE: rtl/core/fdcu_parser.sv
// parser state and the per-byte decode step
module fdcu_parser
    import fdcu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_mode,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output t_rbuf      o_rb
);

    logic  r_mode;
    t_st   r_st;
    t_st   n_st;
    t_st   s;
    t_rbuf rb;
    logic  fin;
    logic  do_text;

    function automatic void put(inout t_rbuf b, input logic [7:0] d, input t_kind k,
                                input logic ok, input t_err e);
        t_res r;
        r.out_byte    = d;
        r.kind        = k;
        r.checksum_ok = ok;
        r.error_code  = e;
        r.last        = 1'b0;
        if (b.n == 2'd0) begin
            b.r0 = r;
            b.n  = 2'd1;
        end else if (b.n == 2'd1) begin
            b.r1 = r;
            b.n  = 2'd2;
        end
    endfunction

    function automatic void frame_clear(inout t_st st);
        st.esc  = 1'b0;
        st.cnt  = 2'd0;
        st.held = 8'd0;
        st.sum  = 8'd0;
    endfunction

    // decoded bytes leave one byte late so the checksum byte stays behind
    function automatic void feed(inout t_st st, inout t_rbuf b, input logic [7:0] d);
        t_kind k;
        k = (st.cnt == 2'd1) ? KIND_CODE : ((st.cnt == 2'd2) ? KIND_TOKEN : KIND_PAYLOAD);
        if (st.cnt != 2'd0) put(b, st.held, k, 1'b0, ERR_NONE);
        st.held = d;
        st.sum  = st.sum + d;
        if (st.cnt != 2'd3) st.cnt = st.cnt + 2'd1;
    endfunction

    function automatic void frame_data(inout t_st st, inout t_rbuf b, input logic [7:0] d);
        if (st.esc) begin
            st.esc = 1'b0;
            feed(st, b, d ^ ESC_XOR);
        end else if (d == ESC_BYTE) begin
            st.esc = 1'b1;
        end else begin
            feed(st, b, d);
        end
    endfunction

    function automatic void frame_end(inout t_st st, inout t_rbuf b);
        t_err e;
        e = st.esc ? ERR_ESCAPE : ((st.cnt != 2'd3) ? ERR_SHORT : ERR_NONE);
        put(b, 8'd0, KIND_FEND, st.sum == GOOD_SUM, e);
        frame_clear(st);
        st.phase = PH_IDLE;
    endfunction

    // cr is held back until the next byte shows whether lf follows
    function automatic void text_byte(inout t_st st, inout t_rbuf b, input logic [7:0] d,
                                      input logic final_b);
        logic done;
        done = 1'b0;
        if (st.cr) begin
            st.cr = 1'b0;
            if (d == CHAR_LF) begin
                put(b, CHAR_LF, KIND_TEXT, 1'b0, ERR_NONE);
                done = 1'b1;
            end else begin
                put(b, CHAR_CR, KIND_TEXT, 1'b0, ERR_NONE);
            end
        end
        if (!done) begin
            if (d == CHAR_CR && !final_b) st.cr = 1'b1;
            else put(b, d, KIND_TEXT, 1'b0, ERR_NONE);
        end
    endfunction

    always_comb begin
        s       = r_st;
        rb      = '0;
        fin     = 1'b0;
        do_text = 1'b0;
        if (!r_mode) begin
            if (s.phase == PH_FRAME) begin
                if (i_byte == FLAG_BYTE) frame_end(s, rb);
                else frame_data(s, rb, i_byte);
            end else if (i_byte == FLAG_BYTE) begin
                if (s.phase == PH_TEXT) begin
                    if (s.cr) put(rb, CHAR_CR, KIND_TEXT, 1'b0, ERR_NONE);
                    s.cr = 1'b0;
                    put(rb, 8'd0, KIND_TEND, 1'b0, ERR_NONE);
                end
                frame_clear(s);
                s.phase = PH_FRAME;
            end else begin
                s.phase = PH_TEXT;
                text_byte(s, rb, i_byte, 1'b0);
            end
        end else begin
            // a text end owed by the previous message goes out first
            if (s.phase == PH_OWED) begin
                put(rb, 8'd0, KIND_TEND, 1'b0, ERR_NONE);
                s.phase = PH_IDLE;
            end
            case (s.phase)
                PH_GOT01: begin
                    if (i_byte == HDR1_BYTE) begin
                        s.phase = PH_GOT90;
                    end else begin
                        put(rb, 8'd0, KIND_DISCARD, 1'b0, ERR_HEADER);
                        s.phase = PH_IDLE;
                    end
                end
                PH_GOT90: begin
                    s.lenh  = i_byte;
                    s.phase = PH_GOTLEN;
                end
                PH_GOTLEN: begin
                    s.left  = {s.lenh, i_byte};
                    s.phase = (s.left == 16'd0) ? PH_IDLE : PH_SELECT;
                end
                PH_SELECT, PH_HFRAME, PH_HTEXT: begin
                    s.left = s.left - 16'd1;
                    fin    = (s.left == 16'd0);
                    if (s.phase == PH_SELECT) begin
                        if (i_byte == FLAG_BYTE) begin
                            frame_clear(s);
                            if (fin) frame_end(s, rb);
                            else s.phase = PH_HFRAME;
                        end else begin
                            s.cr    = 1'b0;
                            s.phase = PH_HTEXT;
                            do_text = 1'b1;
                        end
                    end else if (s.phase == PH_HFRAME) begin
                        // the last counted byte closes the frame whatever it is
                        if (fin) frame_end(s, rb);
                        else frame_data(s, rb, i_byte);
                    end else begin
                        do_text = 1'b1;
                    end
                end
                default: begin
                    if (i_byte == HDR0_BYTE) begin
                        s.phase = PH_GOT01;
                    end else begin
                        put(rb, 8'd0, KIND_DISCARD, 1'b0, ERR_HEADER);
                        s.phase = PH_IDLE;
                    end
                end
            endcase
            if (do_text) begin
                text_byte(s, rb, i_byte, fin);
                if (fin) begin
                    s.cr = 1'b0;
                    if (rb.n != 2'd2) begin
                        put(rb, 8'd0, KIND_TEND, 1'b0, ERR_NONE);
                        s.phase = PH_IDLE;
                    end else begin
                        s.phase = PH_OWED;
                    end
                end
            end
        end
        if (rb.n == 2'd1) rb.r0.last = 1'b1;
        if (rb.n == 2'd2) rb.r1.last = 1'b1;
        n_st = i_fire ? s : r_st;
        o_rb = i_fire ? rb : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_st   <= ST_RESET;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_mode;
            r_st   <= ST_RESET;
        end else begin
            r_st   <= n_st;
        end
    end

    a_esc_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.esc |-> (r_st.phase == PH_FRAME || r_st.phase == PH_HFRAME))
        else $error("escape pending outside a frame");

    a_cr_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.cr |-> (r_st.phase == PH_TEXT || r_st.phase == PH_HTEXT))
        else $error("cr pending outside text");

    a_owed_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.phase == PH_OWED) |-> r_mode)
        else $error("owed text end in flag mode");

endmodule

FILE: rtl/core/fdcu_resq.sv
// result queue: takes up to two results a cycle, delivers one
module fdcu_resq
    import fdcu_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_rbuf         i_push,
    output logic          o_room,
    fdcu_res_if.source    o_res
);

    t_res           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_cnt;
    logic [QAW-1:0] n_wr;
    logic [QAW-1:0] n_rd;
    logic [QAW:0]   n_cnt;
    logic           pop;
    t_res           head;

    assign head              = r_mem[r_rd];
    assign o_res.valid       = (r_cnt != '0);
    assign o_res.out_byte    = head.out_byte;
    assign o_res.kind        = head.kind;
    assign o_res.checksum_ok = head.checksum_ok;
    assign o_res.error_code  = head.error_code;
    assign o_res.last        = head.last;

    assign pop    = o_res.valid && o_res.ready;
    // room for the two results a byte may cause
    assign o_room = (r_cnt <= (QAW+1)'(QDEPTH - 2));

    always_comb begin
        n_wr  = r_wr + QAW'(i_push.n);
        n_rd  = r_rd + QAW'(pop);
        n_cnt = r_cnt + (QAW+1)'(i_push.n) - (QAW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) r_mem[r_wr] <= i_push.r0;
        if (i_push.n == 2'd2) r_mem[r_wr + QAW'(1)] <= i_push.r1;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n != 2'd0) |-> o_room)
        else $error("results pushed without room");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> r_cnt == $past(r_cnt) + (QAW+1)'($past(i_push.n)) - (QAW+1)'($past(pop)))
        else $error("queue count out of step");

endmodule

FILE: rtl/core/frame_decoder_checksum_unstuffing.sv
// top level of the deframer: input register, parser step and result queue
// path: an accepted byte waits in the input register while the queue lacks room; the parser
//   step then decodes it and writes its results into the result queue
// throughput: one byte per cycle while the queue holds at most two results; a byte with
//   two results adds one net entry, so a run of such bytes fills the queue and stalls input
// reset: synchronous active-low i_rst_n clears mode, parser, input register and queue; a mode write
//   also returns the parser to its reset state
module frame_decoder_checksum_unstuffing
    import fdcu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    fdcu_cfg_if.sink   i_cfg,
    fdcu_rx_if.sink    i_rx,
    fdcu_res_if.source o_res
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       room;
    logic       fire;
    t_rbuf      rb;

    assign i_cfg.ready = 1'b1;
    assign fire        = r_in_valid && room;
    assign i_rx.ready  = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) r_in_byte <= i_rx.rx_byte;
    end

    fdcu_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid && i_cfg.ready),
        .i_cfg_mode (i_cfg.serial_mode),
        .i_fire     (fire),
        .i_byte     (r_in_byte),
        .o_rb       (rb)
    );

    fdcu_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rb),
        .o_room  (room),
        .o_res   (o_res)
    );

    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !room) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled byte lost");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_rx.ready)
        else $error("empty input register refuses a request");

    a_fire_pushes_or_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |-> (rb.n == 2'd0))
        else $error("results without a decoded byte");

endmodule
